// File: src/chcb_pkg.sv
// Package for the canonical Huffman code builder: field widths, item mode codes,
// and the command struct that drives the length histogram store.
// No dependencies.
package chcb_pkg;

   // Field widths of the input and result transactions
   localparam int ModeWidth   = 2;
   localparam int SymbolWidth = 9;
   localparam int LenWidth    = 4;
   localparam int CodeWidth   = 15;

   // Longest code length; lengths above it get no code
   localparam int MaxBits = 15;
   localparam int LenTop  = (MaxBits < 15) ? MaxBits : 15;

   // Per-length tables
   localparam int TableDepth = 1 << LenWidth;
   localparam int HistWidth  = 10;
   localparam int NextWidth  = 16;

   // Item modes
   localparam logic [ModeWidth-1:0] ModeClear  = 2'd0;
   localparam logic [ModeWidth-1:0] ModeCount  = 2'd1;
   localparam logic [ModeWidth-1:0] ModeAssign = 2'd2;

   // Command to the histogram store
   typedef struct packed {
      logic                 clear;
      logic [LenWidth-1:0]  rd_addr;
      logic                 wr_en;
      logic [LenWidth-1:0]  wr_addr;
      logic [HistWidth-1:0] wr_data;
   } hist_cmd_type;

endpackage

// File: src/chcb_if.sv
// Valid/ready channel interfaces for the code builder's input and result transactions.
// Depends on chcb_pkg for the field widths.
interface chcb_req_if;
   import chcb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ModeWidth-1:0]   mode;
   logic [SymbolWidth-1:0] symbol;
   logic [LenWidth-1:0]    code_length;

   modport source (output valid, output mode, output symbol, output code_length,
                   input ready);
   modport sink   (input valid, input mode, input symbol, input code_length,
                   output ready);
endinterface

interface chcb_rsp_if;
   import chcb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SymbolWidth-1:0] symbol_out;
   logic [CodeWidth-1:0]   code;
   logic [LenWidth-1:0]    code_bits;
   logic                   has_code;

   modport source (output valid, output symbol_out, output code, output code_bits,
                   output has_code, input ready);
   modport sink   (input valid, input symbol_out, input code, input code_bits,
                   input has_code, output ready);
endinterface

// File: src/chcb_hist_store.sv
// Length histogram store: synchronous memory with registered read, per-entry
// valid bits so a clear takes effect at once. Depends on chcb_pkg.
module chcb_hist_store (
   input  logic                                clock,
   input  logic                                reset,
   input  chcb_pkg::hist_cmd_type              cmd,
   output logic [chcb_pkg::HistWidth-1:0]      rd_data
);
   import chcb_pkg::*;

   logic [HistWidth-1:0]  mem [TableDepth];
   logic [TableDepth-1:0] valid_ff;
   logic [HistWidth-1:0]  rd_mem_ff;
   logic                  rd_valid_ff;

   // Track written entries; reset and clear drop them all
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_mem_ff   <= mem[cmd.rd_addr];
      rd_valid_ff <= valid_ff[cmd.rd_addr];
   end

   // An entry never written since the last clear reads as zero
   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

// File: src/canonical_huffman_code_builder.sv
// Canonical Huffman code builder, DEFLATE style: length histogram, first-code walk,
// and per-symbol code assignment. Depends on chcb_pkg, chcb_if and chcb_hist_store.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | mode, symbol, code_length
//   rsp     | out | valid/ready  | symbol_out, code, code_bits, has_code (assign only)
//
// Clear, unused-mode and zero-length count items are handled in the idle state; other
// count items and assign items pass through the execute state (memory read, then modify
// and write back). The first assign item after reset, a clear or a counted length first
// walks lengths 1..15, one histogram read per cycle, then a fetch state. reset is
// synchronous; histogram valid bits clear at once, no sweep.
// A result waiting in the output register does not block input; an assign item
// holds in its execute state only while the output register is still full.
module canonical_huffman_code_builder (
   input logic          clock,
   input logic          reset,
   chcb_req_if.sink     req,
   chcb_rsp_if.source   rsp
);
   import chcb_pkg::*;

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StExec  = 2'd1;
   localparam logic [1:0] StBuild = 2'd2;
   localparam logic [1:0] StFetch = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [ModeWidth-1:0]   mode_ff, mode_in;
   logic [SymbolWidth-1:0] symbol_ff, symbol_in;
   logic [LenWidth-1:0]    len_ff, len_in;
   logic [LenWidth-1:0]    walk_ff, walk_in;
   logic [NextWidth-1:0]   code_ff, code_in;
   logic                   ready_ff, ready_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SymbolWidth-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic [CodeWidth-1:0]   rsp_code_ff, rsp_code_in;
   logic [LenWidth-1:0]    rsp_bits_ff, rsp_bits_in;
   logic                   rsp_has_ff, rsp_has_in;

   hist_cmd_type           hist_cmd;
   logic [HistWidth-1:0]   hist_rd_data;

   logic [NextWidth-1:0]   next_mem [TableDepth];
   logic [NextWidth-1:0]   next_rd_ff;
   logic [LenWidth-1:0]    next_rd_addr;
   logic                   next_wr_en;
   logic [LenWidth-1:0]    next_wr_addr;
   logic [NextWidth-1:0]   next_wr_data;

   logic                   accept;
   logic                   req_len_ok;
   logic                   len_ok;
   logic                   rsp_free;
   logic [HistWidth-1:0]   prev_count;
   logic [NextWidth-1:0]   walk_code;
   logic [NextWidth-1:0]   len_mask;

   chcb_hist_store u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .rd_data (hist_rd_data)
   );

   // Next-code memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (next_wr_en) begin
         next_mem[next_wr_addr] <= next_wr_data;
      end
      next_rd_ff <= next_mem[next_rd_addr];
   end

   assign req.ready  = (state_ff == StIdle);
   assign accept     = req.valid && req.ready;
   assign req_len_ok = (req.code_length != '0) && (req.code_length <= LenWidth'(LenTop));
   assign len_ok     = (len_ff != '0) && (len_ff <= LenWidth'(LenTop));
   assign rsp_free   = !rsp_valid_ff || rsp.ready;

   // First-code step: code = (code + count[bits-1]) << 1, count[0] taken as zero
   assign prev_count = (walk_ff == LenWidth'(1)) ? '0 : hist_rd_data;
   assign walk_code  = NextWidth'((code_ff + NextWidth'(prev_count)) << 1);
   assign len_mask   = ~({NextWidth{1'b1}} << len_ff);

   // Sequencer: accept, walk, read-modify-write
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      symbol_in     = symbol_ff;
      len_in        = len_ff;
      walk_in       = walk_ff;
      code_in       = code_ff;
      ready_in      = ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_has_in    = rsp_has_ff;

      hist_cmd         = '0;
      hist_cmd.rd_addr = len_ff;
      hist_cmd.wr_addr = len_ff;
      hist_cmd.wr_data = (hist_rd_data == '1) ? hist_rd_data : hist_rd_data + 1'b1;
      next_rd_addr     = len_ff;
      next_wr_en       = 1'b0;
      next_wr_addr     = len_ff;
      next_wr_data     = next_rd_ff + 1'b1;

      case (state_ff)
         StIdle: begin
            hist_cmd.rd_addr = req.code_length;
            next_rd_addr     = req.code_length;
            if (accept) begin
               mode_in   = req.mode;
               symbol_in = req.symbol;
               len_in    = req.code_length;
               case (req.mode)
                  ModeClear: begin
                     hist_cmd.clear = 1'b1;
                     ready_in       = 1'b0;
                  end
                  ModeCount: begin
                     if (req_len_ok) begin
                        ready_in = 1'b0;
                        state_in = StExec;
                     end
                  end
                  ModeAssign: begin
                     if (ready_ff) begin
                        state_in = StExec;
                     end else begin
                        walk_in  = LenWidth'(1);
                        code_in  = '0;
                        state_in = StBuild;
                     end
                  end
                  default: begin
                     // unused mode: drop the transaction
                  end
               endcase
            end
         end
         StBuild: begin
            hist_cmd.rd_addr = walk_ff;
            next_wr_en       = 1'b1;
            next_wr_addr     = walk_ff;
            next_wr_data     = walk_code;
            code_in          = walk_code;
            walk_in          = walk_ff + 1'b1;
            if (walk_ff == LenWidth'(LenTop)) begin
               ready_in = 1'b1;
               state_in = StFetch;
            end
         end
         StFetch: begin
            state_in = StExec;
         end
         StExec: begin
            if (mode_ff == ModeCount) begin
               hist_cmd.wr_en = 1'b1;
               state_in       = StIdle;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = symbol_ff;
               rsp_code_in   = len_ok ? CodeWidth'(next_rd_ff & len_mask) : '0;
               rsp_bits_in   = len_ok ? len_ff : '0;
               rsp_has_in    = len_ok;
               next_wr_en    = len_ok;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      symbol_ff     <= symbol_in;
      len_ff        <= len_in;
      walk_ff       <= walk_in;
      code_ff       <= code_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_has_ff    <= rsp_has_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.symbol_out = rsp_symbol_ff;
   assign rsp.code       = rsp_code_ff;
   assign rsp.code_bits  = rsp_bits_ff;
   assign rsp.has_code   = rsp_has_ff;

`ifndef ASSERT_OFF
   // The first-code walk only runs while the codes are stale
   a_build_stale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StBuild) |-> !ready_ff)
      else $error("first-code walk running with codes marked ready");

   // An assign transaction executes only on fresh first codes
   a_exec_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StExec && mode_ff == ModeAssign) |-> ready_ff)
      else $error("assign executed before first codes were built");

   // A result is loaded only into a free output register
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready && state_ff == StExec && mode_ff == ModeAssign)
      |=> (state_ff == StExec))
      else $error("result loaded over a pending result");

   // Walk finishes at the longest length and then fetches the next code
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StBuild && walk_ff == LenWidth'(LenTop)) |=> (state_ff == StFetch))
      else $error("first-code walk did not end at the longest length");
`endif

endmodule

// File: tb/canonical_huffman_code_builder_tb.sv
// Self-checking testbench for canonical_huffman_code_builder: random length tables,
// an internal code predictor, and field-by-field checks of every code result.
// Depends on chcb_pkg, chcb_if and the code builder RTL.
module canonical_huffman_code_builder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import chcb_pkg::*;

   localparam logic [ModeWidth-1:0] ModeUnused = 2'd3;
   localparam int HistMax      = (1 << HistWidth) - 1;
   localparam int RandomItems  = 1800;
   localparam int SettleCycles = 40;
   localparam int CycleLimit   = 1_000_000;
   localparam int PrintLimit   = 40;

   // Kinds of generated length tables
   localparam int TableComplete = 0;
   localparam int TableRandom   = 1;
   localparam int TableBroken   = 2;

   typedef struct packed {
      logic [ModeWidth-1:0]   mode;
      logic [SymbolWidth-1:0] symbol;
      logic [LenWidth-1:0]    code_length;
   } length_item_type;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol_out;
      logic [CodeWidth-1:0]   code;
      logic [LenWidth-1:0]    code_bits;
      logic                   has_code;
   } code_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chcb_req_if req_ch ();
   chcb_rsp_if rsp_ch ();

   canonical_huffman_code_builder DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #1 clock = ~clock;

   // Predictor copy of the builder tables
   logic [HistWidth-1:0] length_hist [TableDepth];
   logic [NextWidth-1:0] next_code   [TableDepth];
   logic                 first_codes_built;

   length_item_type pending_items [$];
   code_result_type expected_codes [$];

   int  total_items    = 0;
   int  accepted_items = 0;
   int  stim_count     = 0;
   int  mismatches     = 0;
   int  cycles         = 0;
   bit  req_fire       = 1'b0;
   int  send_gap       = 0;
   int  send_calm      = 0;
   int  stall_left     = 0;
   int  drain_calm     = 0;

   task automatic report_mismatch(input string msg);
      if (mismatches < PrintLimit)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic push_item(input logic [ModeWidth-1:0] mode, input int sym, input int len);
      length_item_type it;
      it.mode        = mode;
      it.symbol      = SymbolWidth'(sym);
      it.code_length = LenWidth'(len);
      pending_items.insert(pending_items.size(), it);
      total_items++;
      if (mode != ModeUnused)
         stim_count++;
   endtask

   // Advance the predictor by one accepted transaction; return the code it yields
   function automatic void predict_code(input length_item_type it, output bit produced,
                                        output code_result_type want);
      logic [NextWidth-1:0] walk;
      logic [NextWidth-1:0] c;
      int unsigned          mask;
      int                   len;
      produced = 1'b0;
      want     = '0;
      len      = int'(it.code_length);
      case (it.mode)
         ModeClear: begin
            for (int i = 0; i < TableDepth; i++) begin
               length_hist[i] = '0;
               next_code[i]   = '0;
            end
            first_codes_built = 1'b0;
         end
         ModeCount: begin
            if (len != 0 && len <= LenTop) begin
               if (length_hist[len] < HistMax)
                  length_hist[len] = length_hist[len] + 1'b1;
               first_codes_built = 1'b0;
            end
         end
         ModeAssign: begin
            // Rebuild the first code of each length after any counted length or clear
            if (!first_codes_built) begin
               walk         = '0;
               next_code[0] = '0;
               for (int b = 1; b <= LenTop; b++) begin
                  walk = (walk + ((b == 1) ? '0 : NextWidth'(length_hist[b-1]))) << 1;
                  next_code[b] = walk;
               end
               first_codes_built = 1'b1;
            end
            produced        = 1'b1;
            want.symbol_out = it.symbol;
            if (len != 0 && len <= LenTop) begin
               c              = next_code[len];
               mask           = (32'd1 << len) - 1;
               want.code      = CodeWidth'(32'(c) & mask);
               want.code_bits = it.code_length;
               want.has_code  = 1'b1;
               next_code[len] = c + 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // One table: clear, count, assign in symbol order; broken drops/adds items
   task automatic run_table(input int kind);
      int lens [$];
      int used;
      int idx;
      int l;
      int base;
      int tmp;
      bit broken;
      used   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 60);
      broken = (kind == TableBroken);
      if (kind == TableComplete) begin
         // Split leaves of a full tree until enough symbols have lengths
         lens.insert(lens.size(), 1);
         if (used > 1)
            lens.insert(lens.size(), 1);
         while (lens.size() < used) begin
            idx = $urandom_range(0, lens.size() - 1);
            if (lens[idx] < LenTop) begin
               l         = lens[idx] + 1;
               lens[idx] = l;
               lens.insert(lens.size(), l);
            end
         end
         for (int i = lens.size() - 1; i > 0; i--) begin
            idx       = $urandom_range(0, i);
            tmp       = lens[i];
            lens[i]   = lens[idx];
            lens[idx] = tmp;
         end
      end else begin
         for (int i = 0; i < used; i++)
            lens.insert(lens.size(), $urandom_range(0, (1 << LenWidth) - 1));
      end
      // Scatter unused symbols among the coded ones
      tmp = used + $urandom_range(0, used / 3);
      while (lens.size() < tmp)
         lens.insert($urandom_range(0, lens.size()), 0);
      base = $urandom_range(0, (1 << SymbolWidth) - lens.size());

      if (!(broken && $urandom_range(0, 99) < 40))
         push_item(ModeClear, $urandom_range(0, (1 << SymbolWidth) - 1), $urandom_range(0, 15));
      foreach (lens[i]) begin
         if (!(broken && $urandom_range(0, 99) < 15))
            push_item(ModeCount, base + i, lens[i]);
      end
      foreach (lens[i]) begin
         if (broken && $urandom_range(0, 99) < 10)
            push_item(ModeCount, $urandom_range(0, (1 << SymbolWidth) - 1),
                      $urandom_range(0, 15));
         push_item(ModeAssign, base + i, lens[i]);
         if (broken && $urandom_range(0, 99) < 5)
            push_item(ModeUnused, $urandom_range(0, (1 << SymbolWidth) - 1),
                      $urandom_range(0, 15));
      end
   endtask

   // Drive request transactions at the falling edge
   always @(negedge clock) begin : drive_req
      length_item_type it;
      int              r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         // hold the transaction until it is taken
      end else if (send_gap > 0) begin
         req_ch.valid <= 1'b0;
         send_gap--;
      end else if (pending_items.size() != 0) begin
         it                  = pending_items.pop_front();
         req_ch.valid       <= 1'b1;
         req_ch.mode        <= it.mode;
         req_ch.symbol      <= it.symbol;
         req_ch.code_length <= it.code_length;
         // Pick the idle gap after this transaction, with calm stretches now and then
         r = $urandom_range(0, 99);
         if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
         end else if (r < 2) begin
            send_calm = $urandom_range(20, 80);
            send_gap  = 0;
         end else if (r < 55) begin
            send_gap = 0;
         end else if (r < 88) begin
            send_gap = $urandom_range(1, 3);
         end else begin
            send_gap = $urandom_range(5, 40);
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin : drive_rsp_ready
      int r;
      if (drain_calm > 0) begin
         rsp_ch.ready <= 1'b1;
         drain_calm--;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 3)
            drain_calm = $urandom_range(30, 150);
         else if (r < 25)
            stall_left = $urandom_range(1, 3);
         else if (r < 30)
            stall_left = $urandom_range(5, 40);
      end
   end

   // Predict on accepted requests, check accepted results
   always @(posedge clock) begin : watch
      length_item_type it;
      code_result_type want;
      code_result_type got;
      bit              produced;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         it.mode        = req_ch.mode;
         it.symbol      = req_ch.symbol;
         it.code_length = req_ch.code_length;
         predict_code(it, produced, want);
         if (produced)
            expected_codes.insert(expected_codes.size(), want);
         accepted_items++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.symbol_out = rsp_ch.symbol_out;
         got.code       = rsp_ch.code;
         got.code_bits  = rsp_ch.code_bits;
         got.has_code   = rsp_ch.has_code;
         if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected result symbol %0d", got.symbol_out));
         end else begin
            want = expected_codes.pop_front();
            if (got.symbol_out !== want.symbol_out)
               report_mismatch($sformatf("symbol_out got %0d want %0d",
                                         got.symbol_out, want.symbol_out));
            if (got.code !== want.code)
               report_mismatch($sformatf("symbol %0d code got %0h want %0h",
                                         want.symbol_out, got.code, want.code));
            if (got.code_bits !== want.code_bits)
               report_mismatch($sformatf("symbol %0d code_bits got %0d want %0d",
                                         want.symbol_out, got.code_bits, want.code_bits));
            if (got.has_code !== want.has_code)
               report_mismatch($sformatf("symbol %0d has_code got %0d want %0d",
                                         want.symbol_out, got.has_code, want.has_code));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("[canonical_huffman_code_builder] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      int r;
      req_ch.valid       = 1'b0;
      req_ch.mode        = ModeClear;
      req_ch.symbol      = '0;
      req_ch.code_length = '0;
      rsp_ch.ready       = 1'b0;
      for (int i = 0; i < TableDepth; i++) begin
         length_hist[i] = '0;
         next_code[i]   = '0;
      end
      first_codes_built = 1'b0;

      // Assign with nothing counted, unused length, ignored mode
      push_item(ModeClear, 0, 0);
      push_item(ModeAssign, 0, 5);
      push_item(ModeAssign, 511, 0);
      push_item(ModeUnused, 511, 15);
      // Shortest and longest lengths, zero length ignored on count
      push_item(ModeClear, 511, 15);
      push_item(ModeCount, 0, 1);
      push_item(ModeCount, 1, 2);
      push_item(ModeCount, 2, 15);
      push_item(ModeCount, 3, 15);
      push_item(ModeCount, 4, 0);
      push_item(ModeAssign, 0, 1);
      push_item(ModeAssign, 1, 2);
      push_item(ModeAssign, 2, 15);
      push_item(ModeAssign, 3, 15);
      push_item(ModeAssign, 4, 0);
      push_item(ModeAssign, 5, 15);
      // Count after assigning began forces a rebuild
      push_item(ModeCount, 6, 3);
      push_item(ModeAssign, 6, 3);
      push_item(ModeClear, 0, 0);
      push_item(ModeCount, 511, 15);
      push_item(ModeAssign, 511, 15);
      push_item(ModeUnused, 0, 0);

      // Saturate one histogram entry, then observe it through the next length
      target = stim_count + RandomItems;
      push_item(ModeClear, 0, 0);
      for (int i = 0; i < HistMax + 7; i++)
         push_item(ModeCount, $urandom_range(0, (1 << SymbolWidth) - 1), 4);
      push_item(ModeCount, 300, 5);
      push_item(ModeCount, 301, 5);
      push_item(ModeAssign, 10, 4);
      push_item(ModeAssign, 300, 5);
      push_item(ModeAssign, 301, 5);

      // Mostly well-formed tables, some over-subscribed or broken, some noise
      while (stim_count < target) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            run_table(TableComplete);
         end else if (r < 72) begin
            run_table(TableRandom);
         end else if (r < 90) begin
            run_table(TableBroken);
         end else begin
            repeat ($urandom_range(1, 6))
               push_item(ModeWidth'($urandom_range(0, 3)),
                         $urandom_range(0, (1 << SymbolWidth) - 1), $urandom_range(0, 15));
         end
      end

      // Hold reset, then release it at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all transactions and results, then let the block settle
      while (accepted_items < total_items || expected_codes.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0)
         $display("[canonical_huffman_code_builder] OK");
      else
         $display("[canonical_huffman_code_builder] ERROR");
      $finish;
   end

endmodule

// File: files.f
src/chcb_pkg.sv
src/chcb_if.sv
src/chcb_hist_store.sv
src/canonical_huffman_code_builder.sv
tb/canonical_huffman_code_builder_tb.sv
